// ===== design/imse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// imse_pkg
// Shared types and constants of the induction motor slip estimator: beat
// layouts, sequencer states, serial arithmetic unit control and fixed-point
// scaling constants.
// ============================================================================
package imse_pkg;

    // Timer clock that stamps the control ticks.
    localparam int unsigned TIMER_CLOCK_HZ = 168000000;
    localparam logic [31:0] TIMER_HZ_W     = 32'(TIMER_CLOCK_HZ);

    // Slip guard: |slip| * dt > 0.1 rad  <=>  m > floor(floor(65536 * H / 10) / dt)
    localparam logic [63:0] GUARD_LIMIT = (64'(TIMER_CLOCK_HZ) * 64'd65536) / 64'd10;

    // 1 / (2 pi) in Q0.32, and the rounding half used with it.
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
    localparam logic [15:0] INV_TWO_PI_LO  = INV_TWO_PI_Q32[15:0];
    localparam logic [47:0] ROUND_HALF     = 48'h0000_8000_0000;

    // Configuration space.
    localparam logic [31:0] SLIP_GAIN_RESET = 32'd917504;
    localparam int          ADDR_W          = 3;
    localparam logic        REG_SLIP_GAIN   = 1'b0;   // word index

    // Serial multiply / divide unit.
    localparam int          MUL_BITS = 32;
    localparam int          DIV_BITS = 64;
    localparam int          CNT_W    = $clog2(DIV_BITS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

    typedef struct packed {
        logic               sources_valid;
        logic [31:0]        timestamp;
        logic signed [15:0] rotor_angle;
        logic signed [31:0] rotor_velocity;
        logic signed [15:0] d_current;
        logic signed [15:0] q_current;
    } in_beat_t;

    typedef struct packed {
        logic               active;
        logic signed [15:0] stator_phase;
        logic signed [31:0] stator_velocity;
        logic signed [31:0] slip_speed;
    } out_beat_t;

    typedef struct packed {
        logic start;
        logic do_mul;
        logic do_div;
    } md_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } md_rsp_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K,
        ST_STEP,
        ST_SLIP,
        ST_LIMIT,
        ST_ANGLE,
        ST_PHASE,
        ST_DONE
    } est_state_t;

endpackage

// ===== design/imse_muldiv.sv =====
`timescale 1ns / 1ps
// ============================================================================
// imse_muldiv
// Bit-serial unsigned multiply then divide: result = (opa * opb) / divisor.
// Shift-add multiply, one multiplier bit per cycle, then restoring divide,
// one quotient bit per cycle. Either pass can be skipped.
// ============================================================================
module imse_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  imse_pkg::md_req_t req,
    input  logic [31:0]      opa,
    input  logic [63:0]      opb,
    input  logic [31:0]      divisor,
    output imse_pkg::md_rsp_t rsp,
    output logic [63:0]      result
);
    import imse_pkg::*;

    md_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]       prod_reg, prod_next;
    logic [31:0]       rem_reg, rem_next;

    logic [32:0]       mul_sum;
    logic [32:0]       rem_shift;
    logic [33:0]       rem_trial;
    logic              quo_bit;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    if (req.do_mul) begin
                        state_next = MD_MUL;
                    end else if (req.do_div) begin
                        state_next = MD_DIV;
                    end else begin
                        state_next = MD_DONE;
                    end
                end
            end
            MD_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = req.do_div ? MD_DIV : MD_DONE;
                end
            end
            MD_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        rsp.idle = 1'b0;
        rsp.done = 1'b0;
        case (state_reg)
            MD_IDLE: rsp.idle = 1'b1;
            MD_DONE: rsp.done = 1'b1;
            default: begin
                rsp.idle = 1'b0;
                rsp.done = 1'b0;
            end
        endcase
    end

    assign result = prod_reg;

    // Datapath: one multiplier bit or one quotient bit a cycle.
    always_comb begin
        mul_sum   = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, opa} : 33'd0);
        rem_shift = {rem_reg, prod_reg[63]};
        rem_trial = {1'b0, rem_shift} - {2'b00, divisor};
        quo_bit   = ~rem_trial[33];

        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = '0;
        case (state_reg)
            MD_IDLE: begin
                prod_next = req.do_mul ? {32'd0, opb[31:0]} : opb;
                rem_next  = '0;
            end
            MD_MUL: begin
                prod_next = {mul_sum, prod_reg[31:1]};
                cnt_next  = (cnt_reg == MUL_LAST) ? '0 : cnt_reg + 1'b1;
            end
            MD_DIV: begin
                rem_next  = quo_bit ? rem_trial[31:0] : rem_shift[31:0];
                prod_next = {prod_reg[62:0], quo_bit};
                cnt_next  = (cnt_reg == DIV_LAST) ? '0 : cnt_reg + 1'b1;
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

endmodule

// ===== design/induction_motor_slip_estimator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// induction_motor_slip_estimator
// Slip and stator field angle estimator for indirect field-oriented control.
//
// Usage:
//   s_ channel: one beat per control tick (timestamp, rotor angle and
//     velocity, d/q currents, sources_valid). m_ channel: one result beat per
//     tick (active, stator phase, stator velocity, slip velocity).
//   APB port: slip_gain at byte address 0, written while the block is idle.
//   Sequencing: a tick with sources_valid low, or the first valid tick after
//     that, goes straight to the done step and raises m_valid once the output
//     register is free. An updating tick walks up to six passes of the shared
//     bit-serial multiply/divide unit (flux gain, flux step, slip, guard,
//     angle, phase); the guard pass is skipped when the time step is zero,
//     and the slip and guard passes are skipped when the flux is zero.
//   Throughput: one tick at a time; the next beat can be taken the cycle after
//     the result loads.
//   The next input beat is taken as soon as the sequencer is idle, even while
//     the previous result still sits in the output register. If the receiver
//     stalls, the finished tick waits in the last step until the output
//     register frees.
//   Reset: slip_gain returns to 14.0 (Q16.16), flux, phase offset, timer
//     history and held outputs clear, and the estimator is inactive.
// ============================================================================
module induction_motor_slip_estimator (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input ticks
    input  logic                      s_valid,
    output logic                      s_ready,
    input  imse_pkg::in_beat_t        s_data,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output imse_pkg::out_beat_t       m_data,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [imse_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import imse_pkg::*;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    est_state_t          state_reg, state_next;
    logic [31:0]         slip_gain_reg;
    logic signed [15:0]  flux_reg;          // rotor flux estimate, Q8.8 A
    logic [15:0]         offset_reg;        // slip phase offset, binary angle
    logic [31:0]         prev_time_reg;
    logic                running_reg;
    logic [15:0]         held_angle_reg;
    logic [31:0]         held_speed_reg;
    logic [31:0]         held_slip_reg;

    // Per-tick working registers.
    in_beat_t            in_reg;
    logic [31:0]         dt_reg;
    logic [31:0]         k_reg;             // flux step gain, clamped to 32 bits
    logic [47:0]         m_reg;             // slip magnitude before the guard
    logic [31:0]         slip_mag_reg;
    logic                slip_neg_reg;
    logic [31:0]         r_lo_reg;
    logic [15:0]         rhc_reg;           // low half of upper angle product

    logic                m_valid_reg;
    out_beat_t           m_data_reg;

    // ------------------------------------------------------------------
    // Serial arithmetic unit
    // ------------------------------------------------------------------
    md_req_t             md_req;
    md_rsp_t             md_rsp;
    logic [31:0]         md_opa;
    logic [63:0]         md_opb;
    logic [31:0]         md_divisor;
    logic [63:0]         md_result;

    imse_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .opa     (md_opa),
        .opb     (md_opb),
        .divisor (md_divisor),
        .rsp     (md_rsp),
        .result  (md_result)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic s_fire;
    logic m_fire;
    logic out_load;
    logic cfg_write;

    assign s_fire    = s_valid & s_ready;
    assign m_fire    = m_valid_reg & m_ready;
    assign out_load  = (state_reg == ST_DONE) & (~m_valid_reg | m_ready);
    assign cfg_write = psel & penable & pwrite & pready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[ADDR_W-1:2] == REG_SLIP_GAIN) ? slip_gain_reg : 32'd0;

    // ------------------------------------------------------------------
    // Arithmetic around the serial unit
    // ------------------------------------------------------------------
    logic signed [16:0]  diff;              // Id minus flux
    logic                diff_neg;
    logic [16:0]         diff_abs;
    logic [31:0]         step_mag;
    logic signed [33:0]  step_signed;
    logic signed [33:0]  flux_sum;
    logic signed [15:0]  flux_next;
    logic [15:0]         iq_mag;
    logic [15:0]         flux_mag;
    logic                slip_neg_w;
    logic                guard_hit;
    logic [31:0]         slip_value;
    logic signed [32:0]  speed_sum;
    logic [31:0]         speed_sat;
    logic [31:0]         rhc_full;
    logic [47:0]         angle_round;
    logic [15:0]         angle_step;
    logic [15:0]         offset_next;

    function automatic logic [31:0] slip_limit(input logic [47:0] mag, input logic neg);
        logic [31:0] lim;
        if (neg) begin
            lim = (mag > 48'h0000_8000_0000) ? 32'h8000_0000 : mag[31:0];
        end else begin
            lim = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return lim;
    endfunction

    always_comb begin
        diff     = {in_reg.d_current[15], in_reg.d_current} - {flux_reg[15], flux_reg};
        diff_neg = diff[16];
        diff_abs = diff_neg ? (17'd0 - diff) : diff;

        // Flux moves toward Id by the truncated step, then saturates.
        step_mag    = md_result[47:16];
        step_signed = diff_neg ? (34'sd0 - signed'({2'b00, step_mag}))
                               : signed'({2'b00, step_mag});
        flux_sum    = {{18{flux_reg[15]}}, flux_reg} + step_signed;
        if (flux_sum > 34'sd32767) begin
            flux_next = 16'sh7FFF;
        end else if (flux_sum < -34'sd32768) begin
            flux_next = 16'sh8000;
        end else begin
            flux_next = flux_sum[15:0];
        end

        iq_mag     = in_reg.q_current[15] ? (16'd0 - in_reg.q_current) : in_reg.q_current;
        flux_mag   = flux_reg[15] ? (16'd0 - flux_reg) : flux_reg;
        slip_neg_w = in_reg.q_current[15] ^ flux_reg[15];

        // Guard threshold comes back from the divider in the limit pass.
        guard_hit  = {16'd0, m_reg} > md_result;

        slip_value = slip_neg_reg ? (32'd0 - slip_mag_reg) : slip_mag_reg;
        speed_sum  = {in_reg.rotor_velocity[31], in_reg.rotor_velocity}
                   + {slip_value[31], slip_value};
        if (speed_sum[32] != speed_sum[31]) begin
            speed_sat = speed_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            speed_sat = speed_sum[31:0];
        end

        // Angle step = bits 47:32 of r * (1/2pi) + half; the upper part of r
        // contributes only through the low 16 bits of its product.
        rhc_full    = {16'd0, md_result[47:32]} * {16'd0, INV_TWO_PI_LO};
        angle_round = md_result[47:0] + ROUND_HALF;
        angle_step  = angle_round[47:32] + rhc_reg;
        offset_next = slip_neg_reg ? (offset_reg - angle_step) : (offset_reg + angle_step);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.sources_valid && running_reg) begin
                        state_next = ST_K;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_K: begin
                if (md_rsp.done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (md_rsp.done) begin
                    state_next = (flux_next == 16'sd0) ? ST_ANGLE : ST_SLIP;
                end
            end
            ST_SLIP: begin
                if (md_rsp.done) begin
                    state_next = (dt_reg == 32'd0) ? ST_ANGLE : ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                if (md_rsp.done) begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                if (md_rsp.done) begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (md_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (ready and the serial unit's operands)
    // ------------------------------------------------------------------
    always_comb begin
        s_ready       = 1'b0;
        md_req.start  = 1'b0;
        md_req.do_mul = 1'b0;
        md_req.do_div = 1'b0;
        md_opa        = 32'd0;
        md_opb        = 64'd0;
        md_divisor    = TIMER_HZ_W;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_K: begin
                // k = slip_gain * dt / H
                md_req.start  = md_rsp.idle;
                md_req.do_mul = 1'b1;
                md_req.do_div = 1'b1;
                md_opa        = slip_gain_reg;
                md_opb        = {32'd0, dt_reg};
            end
            ST_STEP: begin
                // |Id - flux| * k
                md_req.start  = md_rsp.idle;
                md_req.do_mul = 1'b1;
                md_opa        = k_reg;
                md_opb        = {48'd0, diff_abs[15:0]};
            end
            ST_SLIP: begin
                // m = slip_gain * |Iq| / |flux|
                md_req.start  = md_rsp.idle;
                md_req.do_mul = 1'b1;
                md_req.do_div = 1'b1;
                md_opa        = slip_gain_reg;
                md_opb        = {48'd0, iq_mag};
                md_divisor    = {16'd0, flux_mag};
            end
            ST_LIMIT: begin
                // guard threshold = GUARD_LIMIT / dt
                md_req.start  = md_rsp.idle;
                md_req.do_div = 1'b1;
                md_opb        = GUARD_LIMIT;
                md_divisor    = dt_reg;
            end
            ST_ANGLE: begin
                // r = |slip| * dt / H
                md_req.start  = md_rsp.idle;
                md_req.do_mul = 1'b1;
                md_req.do_div = 1'b1;
                md_opa        = slip_mag_reg;
                md_opb        = {32'd0, dt_reg};
            end
            ST_PHASE: begin
                // low word of r times 1/(2 pi)
                md_req.start  = md_rsp.idle;
                md_req.do_mul = 1'b1;
                md_opa        = INV_TWO_PI_Q32;
                md_opb        = {32'd0, r_lo_reg};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Architectural state and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slip_gain_reg  <= SLIP_GAIN_RESET;
            flux_reg       <= '0;
            offset_reg     <= '0;
            prev_time_reg  <= '0;
            running_reg    <= 1'b0;
            held_angle_reg <= '0;
            held_speed_reg <= '0;
            held_slip_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_write && (paddr[ADDR_W-1:2] == REG_SLIP_GAIN)) begin
                slip_gain_reg <= pwdata;
            end

            if (s_fire) begin
                if (!s_data.sources_valid) begin
                    // drop out of the running state, keep the timer history
                    running_reg <= 1'b0;
                end else begin
                    prev_time_reg <= s_data.timestamp;
                    if (!running_reg) begin
                        // first valid tick: restart the estimate
                        flux_reg    <= '0;
                        offset_reg  <= '0;
                        running_reg <= 1'b1;
                    end
                end
            end

            if ((state_reg == ST_STEP) && md_rsp.done) begin
                flux_reg <= flux_next;
            end

            if ((state_reg == ST_PHASE) && md_rsp.done) begin
                offset_reg     <= offset_next;
                held_angle_reg <= in_reg.rotor_angle + offset_next;
                held_speed_reg <= speed_sat;
                held_slip_reg  <= slip_value;
            end

            // Output register: load the finished tick, drop it once taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-tick working registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg       <= s_data;
            dt_reg       <= s_data.timestamp - prev_time_reg;
            slip_mag_reg <= '0;
            slip_neg_reg <= 1'b0;
        end

        if ((state_reg == ST_K) && md_rsp.done) begin
            k_reg <= (|md_result[63:32]) ? 32'hFFFF_FFFF : md_result[31:0];
        end

        if ((state_reg == ST_SLIP) && md_rsp.done) begin
            m_reg        <= md_result[47:0];
            slip_neg_reg <= slip_neg_w;
            if (dt_reg == 32'd0) begin
                // no time has passed: no guard applies
                slip_mag_reg <= slip_limit(md_result[47:0], slip_neg_w);
            end
        end

        if ((state_reg == ST_LIMIT) && md_rsp.done) begin
            slip_mag_reg <= guard_hit ? 32'd0 : slip_limit(m_reg, slip_neg_reg);
        end

        if ((state_reg == ST_ANGLE) && md_rsp.done) begin
            r_lo_reg <= md_result[31:0];
            rhc_reg  <= rhc_full[15:0];
        end

        if (out_load) begin
            m_data_reg.active          <= running_reg;
            m_data_reg.stator_phase    <= held_angle_reg;
            m_data_reg.stator_velocity <= held_speed_reg;
            m_data_reg.slip_speed      <= held_slip_reg;
        end
    end

endmodule

// ===== bench/induction_motor_slip_estimator_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// induction_motor_slip_estimator_test
// Self-checking bench for the slip estimator. Drives control ticks into the
// s_ channel and programs slip_gain over APB. A bit-exact model of the
// estimator computes the expected result of each accepted tick, and every
// m_ beat is checked field by field against it. The directed tests cover
// missing sources, restart, zero time step, the half-turn angle, timer wrap,
// the slip guard and all saturations. The random traffic then runs under
// several gains and idle patterns, and includes a long output stall.
// ============================================================================
module induction_motor_slip_estimator_test;
    import imse_pkg::*;

    localparam int unsigned RUN_LIMIT_CYCLES = 3_000_000;
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned DRAIN_CYCLES     = 600;
    localparam int unsigned HOLD_CYCLES      = 4000;

    // Register map: slip_gain at word 0, the next word is unmapped.
    localparam logic [ADDR_W-1:0] SLIP_GAIN_ADDR = {REG_SLIP_GAIN, 2'b00};
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR  = ADDR_W'(4);

    localparam longint unsigned TICK_HZ  = 64'(TIMER_CLOCK_HZ);
    localparam longint          SPEED_MAX = 64'sd2147483647;
    localparam longint          SPEED_MIN = -64'sd2147483648;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Estimator state as the bench sees it.
    logic [31:0]        gain_model    = SLIP_GAIN_RESET;
    logic signed [15:0] flux_model    = '0;
    logic [15:0]        offset_model  = '0;
    logic [31:0]        last_stamp    = '0;
    logic               running_model = 1'b0;
    logic [15:0]        held_angle    = '0;
    logic [31:0]        held_speed    = '0;
    logic [31:0]        held_slip     = '0;

    out_beat_t   pending_results[$];
    int          errors        = 0;
    int          send_idle_pct = 15;
    int          recv_idle_pct = 74;
    logic        hold_ask      = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;
    logic [31:0] stim_clock    = '0;

    induction_motor_slip_estimator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Fixed-point helpers and the tick estimate
    // ------------------------------------------------------------------------
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the estimator state by one tick and return the beat it reports.
    function automatic out_beat_t estimate_tick(in_beat_t b);
        logic [31:0]     gap32;
        longint unsigned gap, k, pull, m, sm, r, turn;
        longint          diff, flux_next, slip;
        logic            neg;
        out_beat_t       o;
        if (!b.sources_valid) begin
            running_model = 1'b0;
        end else begin
            // Time step in timer counts, modulo 2^32.
            gap32      = b.timestamp - last_stamp;
            gap        = 64'(gap32);
            last_stamp = b.timestamp;
            if (!running_model) begin
                // Restart: clear flux and offset, keep the held outputs.
                flux_model    = '0;
                offset_model  = '0;
                running_model = 1'b1;
            end else begin
                // Forward Euler step of the flux toward Id, truncated toward zero.
                k         = (64'(gain_model) * gap) / TICK_HZ;
                diff      = longint'($signed(b.d_current)) - longint'(flux_model);
                pull      = (magnitude(diff) * k) >> 16;
                flux_next = (diff < 0) ? longint'(flux_model) - longint'(pull)
                                       : longint'(flux_model) + longint'(pull);
                flux_model = 16'(clamp(flux_next, -32768, 32767));

                // Slip = gain * Iq / flux; zero on no flux or a step over 0.1 rad.
                slip = 0;
                if (flux_model != 0) begin
                    m   = (64'(gain_model) * magnitude(longint'($signed(b.q_current))))
                          / magnitude(longint'(flux_model));
                    neg = ($signed(b.q_current) < 0) != (flux_model < 0);
                    if (!(gap > 0 && m > (64'd65536 * TICK_HZ) / (64'd10 * gap))) begin
                        if (neg)
                            slip = (m > 64'h8000_0000) ? SPEED_MIN : -longint'(m);
                        else
                            slip = (m > 64'h7FFF_FFFF) ? SPEED_MAX : longint'(m);
                    end
                end
                held_slip  = slip[31:0];
                held_speed = 32'(clamp(longint'($signed(b.rotor_velocity)) + slip,
                                       SPEED_MIN, SPEED_MAX));

                // Integrate slip into the offset angle, rounded to the nearest step.
                sm   = magnitude(slip);
                r    = (sm * gap) / TICK_HZ;
                turn = (r * 64'(INV_TWO_PI_Q32) + 64'h8000_0000) >> 32;
                if (slip < 0)
                    offset_model = offset_model - turn[15:0];
                else
                    offset_model = offset_model + turn[15:0];
                held_angle = b.rotor_angle + offset_model;
            end
        end
        o.active          = running_model;
        o.stator_phase    = held_angle;
        o.stator_velocity = held_speed;
        o.slip_speed      = held_slip;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: predict on each input beat, compare each output beat
    // ------------------------------------------------------------------------
    task automatic match_field(string field, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_results.push_back(estimate_tick(s_data));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result beat, expected none, actual %p",
                             $time, m_data);
                end else begin
                    want = pending_results.pop_front();
                    match_field("active", longint'(want.active), longint'(m_data.active));
                    match_field("stator_phase", longint'($signed(want.stator_phase)),
                                longint'($signed(m_data.stator_phase)));
                    match_field("stator_velocity", longint'($signed(want.stator_velocity)),
                                longint'($signed(m_data.stator_velocity)));
                    match_field("slip_speed", longint'($signed(want.slip_speed)),
                                longint'($signed(m_data.slip_speed)));
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when a test asks for it.
    always @(posedge aclk) begin
        if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_beat_t make_tick(logic valid, logic [31:0] stamp,
                                           logic [15:0] phase, logic [31:0] speed,
                                           logic [15:0] id, logic [15:0] iq);
        in_beat_t b;
        b.sources_valid  = valid;
        b.timestamp      = stamp;
        b.rotor_angle    = phase;
        b.rotor_velocity = speed;
        b.d_current      = id;
        b.q_current      = iq;
        return b;
    endfunction

    // Mostly moderate currents of either sign, sometimes anything at all.
    function automatic logic [15:0] random_current(int unsigned span);
        logic [15:0] v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = 16'($urandom_range(0, span));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Build one tick of a running drive: mostly sane time steps, with zero
    // steps, wild steps and dropped sources mixed in.
    function automatic in_beat_t random_tick();
        in_beat_t    b;
        int unsigned roll;
        logic [31:0] gap;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            gap = '0;
        else if (roll < 7)
            gap = $urandom;
        else if (roll < 25)
            gap = $urandom_range(1, 2000);
        else
            gap = $urandom_range(2000, 400000);
        stim_clock += gap;
        b.sources_valid  = ($urandom_range(0, 99) >= 6);
        b.timestamp      = b.sources_valid ? stim_clock : $urandom;
        b.rotor_angle    = 16'($urandom);
        b.rotor_velocity = $urandom;
        b.d_current      = random_current(12000);
        b.q_current      = random_current(3000);
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until it is taken. Valid
    // stays high when the next beat follows with no gap.
    task automatic send_tick(in_beat_t b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every expected result is in and the block has gone quiet.
    // Step past the current edge first so the beat taken at this edge is counted.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready. The caller
    // drops psel after its last transfer.
    task automatic apb_access(logic write, logic [ADDR_W-1:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    // Write a register while idle, then read slip_gain back.
    task automatic program_register(logic [ADDR_W-1:0] addr, logic [31:0] value);
        logic [31:0] readback;
        settle();
        apb_access(1'b1, addr, value, readback);
        if (addr == SLIP_GAIN_ADDR)
            gain_model = value;
        apb_access(1'b0, SLIP_GAIN_ADDR, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== gain_model) begin
            errors++;
            $display("%0t ns: slip_gain readback, expected %0d, actual %0d",
                     $time, gain_model, readback);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Missing sources, restart, zero step with the half-turn angle, the slip
    // guard, timer wrap, and a restart after sources drop again.
    task automatic test_startup_and_restart();
        send_tick(make_tick(1'b0, $urandom, 16'($urandom), $urandom,
                            16'($urandom), 16'($urandom)));
        send_tick(make_tick(1'b1, 32'd1000, 16'h7FFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF));
        // Same stamp: nothing moves, a rotor angle of -pi comes straight through.
        send_tick(make_tick(1'b1, 32'd1000, 16'h8000, 32'h8000_0000, 16'h7FFF, 16'h8000));
        // One millisecond: small flux against a large Iq trips the guard.
        send_tick(make_tick(1'b1, 32'd169000, 16'h0000, 32'h0000_0000, 16'h7FFF, 16'h7FFF));
        send_tick(make_tick(1'b1, 32'd185800, 16'd1234, 32'h0064_0000, 16'h8000, 16'h8000));
        send_tick(make_tick(1'b1, 32'hFFFF_FFF0, 16'hC000, 32'hFF9C_0000, 16'd2560, 16'd256));
        // Stamp wraps past zero: the step is small.
        send_tick(make_tick(1'b1, 32'h0000_0010, 16'h4000, 32'h0010_0000, 16'd2560, 16'hFF00));
        send_tick(make_tick(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_tick(make_tick(1'b1, 32'h0000_5000, 16'h0001, 32'h0000_0001, 16'h0001, 16'h0001));
    endtask

    // Largest and smallest gain: slip and speed saturation both ways, flux
    // saturation both ways, zero slip at zero gain, and the unmapped word.
    task automatic test_gain_extremes();
        logic [31:0] t;
        program_register(SLIP_GAIN_ADDR, 32'hFFFF_FFFF);
        t = 32'h4000_0000;
        send_tick(make_tick(1'b0, t, 16'h0000, 32'h0, 16'h0, 16'h0));
        send_tick(make_tick(1'b1, t, 16'h0000, 32'h0, 16'h0, 16'h0));
        // One count at full gain pulls the flux to 1; Iq of 1 saturates slip.
        send_tick(make_tick(1'b1, t + 1, 16'h1000, 32'h7FFF_FFFF, 16'd3000, 16'd1));
        send_tick(make_tick(1'b1, t + 2, 16'hF000, 32'h8000_0000, 16'd1, 16'hFFFF));
        send_tick(make_tick(1'b1, t + 3, 16'h0100, 32'h0, 16'd1, 16'h8000));
        // Half-range steps drive the flux into both rails.
        t = t + 3 + 32'h8000_0000;
        send_tick(make_tick(1'b1, t, 16'h0200, 32'h0, 16'h8000, 16'h7FFF));
        t = t + 32'h8000_0000;
        send_tick(make_tick(1'b1, t, 16'h0300, 32'h0, 16'h7FFF, 16'h7FFF));
        send_tick(make_tick(1'b1, t + 168, 16'h0400, 32'h7000_0000, 16'h7FFF, 16'h7FFF));
        program_register(SLIP_GAIN_ADDR, 32'd0);
        send_tick(make_tick(1'b1, t + 16968, 16'h0500, 32'h0001_0000, 16'd5000, 16'd5000));
        program_register(UNMAPPED_ADDR, 32'hDEAD_BEEF);
        send_tick(make_tick(1'b1, t + 33768, 16'h0600, 32'h0002_0000, 16'd5000, 16'hEC78));
        stim_clock = t + 33768;
        program_register(SLIP_GAIN_ADDR, SLIP_GAIN_RESET);
    endtask

    // Hold the result channel for a long stretch while ticks keep coming, so
    // the output register fills and the input stalls behind it.
    task automatic test_output_backpressure();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        hold_ask      = 1'b1;
        repeat (8) send_tick(random_tick());
        send_idle_pct = saved_idle;
        settle();
    endtask

    task automatic test_random_ticks(int count, logic [31:0] gain);
        program_register(SLIP_GAIN_ADDR, gain);
        repeat (count) send_tick(random_tick());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_startup_and_restart();
        test_gain_extremes();
        test_output_backpressure();

        // Sender mostly busy, receiver mostly stalled.
        test_random_ticks(125, SLIP_GAIN_RESET);
        test_random_ticks(125, 32'h0064_0000);

        // Swap: sender mostly idle, receiver mostly ready.
        send_idle_pct = 74;
        recv_idle_pct = 15;
        test_random_ticks(125, 32'hFFFF_FFFF);
        test_random_ticks(125, 32'd0);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ticks(125, $urandom_range(1, 32'h00FF_FFFF));
        test_random_ticks(125, $urandom);

        // Drain, then give a stray beat time to show up.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
